// ----- rtl/utf8_byte_stream_decoder_unit_defines.svh -----
// assertion macros used by the utf8 decoder top level
`ifndef UTF8_BYTE_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_BYTE_STREAM_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define UTF8D_ASSERT_NOW(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("utf8 decoder check failed");
// next-cycle implication, checked outside reset
`define UTF8D_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("utf8 decoder check failed");
`else
`define UTF8D_ASSERT_NOW(label, clk, rst, cond, conseq)
`define UTF8D_ASSERT_NEXT(label, clk, rst, cond, conseq)
`endif

`endif

// ----- rtl/utf8d_pkg.sv -----
// types and constants for the utf8 byte stream decoder
package utf8d_pkg;

   localparam int BYTE_W       = 8;
   localparam int CODE_POINT_W = 31;
   localparam int REM_W        = 3;
   localparam int CONT_BITS    = 6;

   // lead byte patterns, longest form first
   localparam logic [BYTE_W-1:0] LEAD6_MASK = 8'b11111100;
   localparam logic [BYTE_W-1:0] LEAD5_MASK = 8'b11111000;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'b11110000;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'b11100000;
   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'b11000000;
   localparam logic [BYTE_W-1:0] CONT_MASK  = 8'b10000000;

   // payload bits carried by each byte form
   localparam logic [BYTE_W-1:0] CONT_PAYLOAD  = 8'b00111111;
   localparam logic [BYTE_W-1:0] LEAD2_PAYLOAD = 8'b00011111;
   localparam logic [BYTE_W-1:0] LEAD3_PAYLOAD = 8'b00001111;
   localparam logic [BYTE_W-1:0] LEAD4_PAYLOAD = 8'b00000111;
   localparam logic [BYTE_W-1:0] LEAD5_PAYLOAD = 8'b00000011;
   localparam logic [BYTE_W-1:0] LEAD6_PAYLOAD = 8'b00000001;

   // bytes still expected after each lead form
   localparam logic [REM_W-1:0] LEAD6_REM = 3'd5;
   localparam logic [REM_W-1:0] LEAD5_REM = 3'd4;
   localparam logic [REM_W-1:0] LEAD4_REM = 3'd3;
   localparam logic [REM_W-1:0] LEAD3_REM = 3'd2;
   localparam logic [REM_W-1:0] LEAD2_REM = 3'd1;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data_byte;
      logic              stream_end;
   } stage_type;

   typedef struct packed {
      logic advance;
      logic idle;
   } core_status_type;

endpackage

// ----- rtl/utf8d_req_if.sv -----
// request channel carrying one stream byte or the end of input
interface utf8d_req_if import utf8d_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              stream_end;

   modport source (output valid, output data_byte, output stream_end, input ready);
   modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

// ----- rtl/utf8d_rsp_if.sv -----
// response channel carrying a code point or the end marker
interface utf8d_rsp_if import utf8d_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CODE_POINT_W-1:0] code_point;
   logic                    end_marker;

   modport source (output valid, output code_point, output end_marker, input ready);
   modport sink   (input valid, input code_point, input end_marker, output ready);
endinterface

// ----- rtl/utf8d_csr_if.sv -----
// write channel for the end mode register
interface utf8d_csr_if;
   logic valid;
   logic ready;
   logic end_mode;

   modport source (output valid, output end_mode, input ready);
   modport sink   (input valid, input end_mode, output ready);
endinterface

// ----- rtl/utf8d_in_stage.sv -----
// input register holding one request ahead of the decode step
module utf8d_in_stage import utf8d_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   utf8d_req_if.sink          req_chan,
   input  logic               advance,
   output stage_type          stage
);

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] data_byte_ff;
   logic              stream_end_ff;
   logic              take;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_byte_ff  <= req_chan.data_byte;
         stream_end_ff <= req_chan.stream_end;
      end
   end

   assign stage.valid      = valid_ff;
   assign stage.data_byte  = data_byte_ff;
   assign stage.stream_end = stream_end_ff;

endmodule

// ----- rtl/utf8d_core.sv -----
// decode step: character state, accumulator update and response register
module utf8d_core import utf8d_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  stage_type          stage,
   input  logic               end_mode,
   utf8d_rsp_if.source        rsp_chan,
   output core_status_type    status
);

   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [CODE_POINT_W-1:0] acc_ff, acc_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CODE_POINT_W-1:0] code_point_ff;
   logic                    end_marker_ff;

   logic                    advance;
   logic                    step;
   logic [REM_W-1:0]        rem_dec;
   logic [REM_W-1:0]        rem_upd;
   logic [CODE_POINT_W-1:0] acc_upd;
   logic                    emit;
   logic [CODE_POINT_W-1:0] cp_out;
   logic                    marker_out;
   logic [BYTE_W-1:0]       b;

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign step    = stage.valid && advance;
   assign b       = stage.data_byte;

   // every byte uses up one expected byte; idle expects just this one
   assign rem_dec = (rem_ff == '0) ? '0 : rem_ff - REM_W'(1);

   always_comb begin
      rem_upd = rem_dec;
      acc_upd = acc_ff;
      priority if ((b & LEAD6_MASK) == LEAD6_MASK) begin
         acc_upd = CODE_POINT_W'(b & LEAD6_PAYLOAD);
         rem_upd = LEAD6_REM;
      end else if ((b & LEAD5_MASK) == LEAD5_MASK) begin
         acc_upd = CODE_POINT_W'(b & LEAD5_PAYLOAD);
         rem_upd = LEAD5_REM;
      end else if ((b & LEAD4_MASK) == LEAD4_MASK) begin
         acc_upd = CODE_POINT_W'(b & LEAD4_PAYLOAD);
         rem_upd = LEAD4_REM;
      end else if ((b & LEAD3_MASK) == LEAD3_MASK) begin
         acc_upd = CODE_POINT_W'(b & LEAD3_PAYLOAD);
         rem_upd = LEAD3_REM;
      end else if ((b & LEAD2_MASK) == LEAD2_MASK) begin
         acc_upd = CODE_POINT_W'(b & LEAD2_PAYLOAD);
         rem_upd = LEAD2_REM;
      end else if ((b & CONT_MASK) == CONT_MASK) begin
         acc_upd = {acc_ff[CODE_POINT_W-CONT_BITS-1:0], b[CONT_BITS-1:0]};
      end else begin
         acc_upd = CODE_POINT_W'(b);
      end
   end

   always_comb begin
      emit       = 1'b0;
      cp_out     = '0;
      marker_out = 1'b0;
      rem_in     = rem_ff;
      acc_in     = acc_ff;
      if (stage.stream_end) begin
         emit       = 1'b1;
         cp_out     = end_mode ? acc_ff : '0;
         marker_out = !end_mode;
         rem_in     = '0;
         acc_in     = '0;
      end else if (rem_upd == '0) begin
         emit   = 1'b1;
         cp_out = acc_upd;
         rem_in = '0;
         acc_in = '0;
      end else begin
         rem_in = rem_upd;
         acc_in = acc_upd;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = stage.valid && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            rem_ff <= rem_in;
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         code_point_ff <= cp_out;
         end_marker_ff <= marker_out;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.code_point = code_point_ff;
   assign rsp_chan.end_marker = end_marker_ff;

   assign status.advance = advance;
   assign status.idle    = (rem_ff == '0);

endmodule

// ----- rtl/utf8_byte_stream_decoder_unit.sv -----
// top level of the utf8 byte stream decoder
// Lenient UTF-8 decoder taking one byte per request and returning a code point
// once a character (1 to 6 bytes, 0xFE/0xFF counted as 6-byte leads) is
// complete. It accepts one request every cycle with no bubbles while responses
// are taken. A request waits in the input register, where the decode step
// updates the character state once the response register is free or being
// taken; a completing byte also loads the response register, which presents
// the response. While a response waits, the request behind it holds in the
// input register and the request side stalls. A stream_end request always
// gives one response: with end_mode 0 an end marker (partial character
// dropped), with end_mode 1 the partial value. Write end_mode only while no
// request is in flight; csr writes are always taken.
`include "utf8_byte_stream_decoder_unit_defines.svh"

module utf8_byte_stream_decoder_unit import utf8d_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   utf8d_req_if.sink    req_chan,
   utf8d_rsp_if.source  rsp_chan,
   utf8d_csr_if.sink    csr_chan
);

   logic            end_mode_ff;
   stage_type       stage;
   core_status_type status;
   logic            end_step;
   logic            lead_step;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         end_mode_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         end_mode_ff <= csr_chan.end_mode;
      end
   end

   utf8d_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (status.advance),
      .stage    (stage)
   );

   utf8d_core u_core (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage),
      .end_mode (end_mode_ff),
      .rsp_chan (rsp_chan),
      .status   (status)
   );

   assign end_step  = stage.valid && stage.stream_end && status.advance;
   assign lead_step = stage.valid && !stage.stream_end && status.advance &&
                      ((stage.data_byte & LEAD2_MASK) == LEAD2_MASK);

   // end of input always yields a response and leaves the decoder idle
   `UTF8D_ASSERT_NEXT(a_end_responds, clock, reset, end_step, rsp_chan.valid)
   `UTF8D_ASSERT_NEXT(a_end_idles, clock, reset, end_step, status.idle)
   // a lead byte opens a character and never completes one
   `UTF8D_ASSERT_NEXT(a_lead_no_rsp, clock, reset, lead_step, !rsp_chan.valid && !status.idle)
   // the end marker carries no code point
   `UTF8D_ASSERT_NOW(a_marker_zero, clock, reset, rsp_chan.valid && rsp_chan.end_marker, rsp_chan.code_point == '0)

endmodule
